// ===== rtl/core/arpl_pkg.sv =====
// ----------------------------------------------------------------------------
// arpl_pkg
// Shared types and constants for the ARP learning table.
// ----------------------------------------------------------------------------
package arpl_pkg;

    localparam int CNT_W      = 64;
    localparam int MAC_W      = 48;
    localparam int IP_W       = 32;
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 312;

    // input tdata bit offsets
    localparam int OFF_ETH   = 0;
    localparam int OFF_WHOLE = 16;
    localparam int OFF_HWT   = 17;
    localparam int OFF_PRT   = 33;
    localparam int OFF_HWL   = 49;
    localparam int OFF_PRL   = 57;
    localparam int OFF_OPC   = 65;
    localparam int OFF_MAC   = 81;
    localparam int OFF_IP    = 129;
    localparam int OFF_IDX   = 161;
    localparam int OFF_RTR   = 166;

    localparam logic [15:0] ETH_ARP   = 16'h0806;
    localparam logic [15:0] HW_ETHER  = 16'h0001;
    localparam logic [15:0] PROTO_IP4 = 16'h0800;
    localparam logic [7:0]  HW_LEN    = 8'd6;
    localparam logic [7:0]  PROTO_LEN = 8'd4;
    localparam logic [15:0] OP_REQ    = 16'd1;
    localparam logic [15:0] OP_REP    = 16'd2;

    typedef enum logic [1:0] {
        CMD_FRAME  = 2'd0,
        CMD_IFACE  = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        OC_PASSED  = 4'd0,
        OC_OTHER   = 4'd1,
        OC_OWN_MAC = 4'd2,
        OC_LEARNED = 4'd3,
        OC_UPDATED = 4'd4,
        OC_SAME    = 4'd5,
        OC_FULL    = 4'd6,
        OC_IFACE   = 4'd7,
        OC_LOOKUP  = 4'd8
    } t_outcome;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_IF_SCAN,
        ST_TB_SCAN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic     load;
        logic     start_if;
        logic     start_tb;
        logic     bump_req;
        logic     bump_rep;
        logic     wr_iface;
        logic     tbl_update;
        logic     tbl_insert;
        logic     out_load;
        logic     out_lookup;
        t_outcome outcome;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic frame_ok;
        logic op_req;
        logic op_rep;
        logic scan_done;
        logic scan_hit;
        logic mac_same;
        logic tbl_full;
        logic out_busy;
    } t_dp_sts;

endpackage

// ===== rtl/core/arp_learning_table_unit.sv =====
// ----------------------------------------------------------------------------
// arp_learning_table_unit
// ARP header check and sender IP to MAC learning in an associative table.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream carries one command per transaction. tuser is the command:
//    frame (parsed ARP fields), interface write, or IP lookup.
//  - Master stream returns exactly one result per command: tuser is the
//    outcome code, tdata carries the lookup result and the four counters.
//  - One command is in work at a time. tready is high only while idle.
//  - Checks, interface writes and rejected frames go from accept through
//    the decode and output states to tvalid; a learning frame scans
//    NUM_IFACES interfaces and then the used table entries, one entry
//    per cycle through the single compare unit. A lookup scans the used
//    table entries. Scans stop early on a match.
//  - The result sits in an output register; the next command is accepted
//    while it waits. If the receiver stalls, a finished second result waits
//    until the register frees.
//  - Reset (synchronous, active low) clears the fill level, the counters,
//    the router flags and the handshakes; table contents are not cleared.
// ----------------------------------------------------------------------------
module arp_learning_table_unit #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int NUM_IFACES    = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] ether_type, [16] header_whole, [32:17] hw_type,
    // [48:33] proto_type, [56:49] hw_addr_len, [64:57] proto_addr_len,
    // [80:65] opcode, [128:81] mac_addr, [160:129] ip_addr,
    // [165:161] iface_index, [166] iface_is_router, [167] zero
    input  logic [arpl_pkg::IN_DATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] found, [48:1] found_mac, [112:49] requests_seen,
    // [176:113] replies_seen, [240:177] learned_total,
    // [304:241] updated_total, [311:305] zero
    output logic [arpl_pkg::OUT_DATA_W-1:0] m_tdata,
    // [3:0] outcome
    output logic [3:0]                      m_tuser
);
    import arpl_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    arpl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    arpl_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NUM_IFACES    (NUM_IFACES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/core/arpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// arpl_ctrl
// Sequencer: decodes the command and steps the scans and table writes.
// ----------------------------------------------------------------------------
module arpl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  arpl_pkg::t_dp_sts i_sts,
    output arpl_pkg::t_dp_cmd o_cmd
);
    import arpl_pkg::*;

    t_state   r_state, n_state;
    t_outcome r_oc, n_oc;
    logic     r_lookup, n_lookup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_oc     <= OC_PASSED;
            r_lookup <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_oc     <= n_oc;
            r_lookup <= n_lookup;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_oc       = r_oc;
        n_lookup   = r_lookup;
        o_cmd      = '0;
        o_cmd.outcome = r_oc;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_lookup = 1'b0;
                n_state  = ST_OUT;
                case (i_sts.cmd)
                    CMD_FRAME: begin
                        if (!i_sts.frame_ok) begin
                            n_oc = OC_PASSED;
                        end else if (i_sts.op_req || i_sts.op_rep) begin
                            o_cmd.bump_req = i_sts.op_req;
                            o_cmd.bump_rep = i_sts.op_rep;
                            o_cmd.start_if = 1'b1;
                            n_state        = ST_IF_SCAN;
                        end else begin
                            n_oc = OC_OTHER;
                        end
                    end
                    CMD_IFACE: begin
                        o_cmd.wr_iface = 1'b1;
                        n_oc           = OC_IFACE;
                    end
                    CMD_LOOKUP: begin
                        o_cmd.start_tb = 1'b1;
                        n_lookup       = 1'b1;
                        n_state        = ST_TB_SCAN;
                    end
                    default: n_oc = OC_PASSED;
                endcase
            end
            ST_IF_SCAN: begin
                if (i_sts.scan_done) begin
                    if (i_sts.scan_hit) begin
                        n_oc    = OC_OWN_MAC;
                        n_state = ST_OUT;
                    end else begin
                        o_cmd.start_tb = 1'b1;
                        n_state        = ST_TB_SCAN;
                    end
                end
            end
            ST_TB_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_OUT;
                    if (r_lookup) begin
                        n_oc = OC_LOOKUP;
                    end else if (i_sts.scan_hit) begin
                        if (i_sts.mac_same) begin
                            n_oc = OC_SAME;
                        end else begin
                            o_cmd.tbl_update = 1'b1;
                            n_oc             = OC_UPDATED;
                        end
                    end else if (i_sts.tbl_full) begin
                        n_oc = OC_FULL;
                    end else begin
                        o_cmd.tbl_insert = 1'b1;
                        n_oc             = OC_LEARNED;
                    end
                end
            end
            ST_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_lookup = r_lookup;
                    n_state          = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/arpl_dp.sv =====
// ----------------------------------------------------------------------------
// arpl_dp
// Datapath: item register, interface store, learning table, scan unit,
// counters and output register.
// ----------------------------------------------------------------------------
module arpl_dp #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int NUM_IFACES    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [arpl_pkg::IN_DATA_W-1:0]      i_s_tdata,
    input  logic [1:0]                          i_s_tuser,
    input  arpl_pkg::t_dp_cmd                   i_cmd,
    output arpl_pkg::t_dp_sts                   o_sts,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [arpl_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic [3:0]                          o_m_tuser
);
    import arpl_pkg::*;

    localparam int AW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int IW  = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;
    localparam int UW  = $clog2(TABLE_ENTRIES + 1);
    localparam int IFW = $clog2(NUM_IFACES + 1);
    localparam int CW  = (UW > IFW) ? UW : IFW;

    // latched item
    logic [IN_DATA_W-1:0] r_item;
    t_cmd                 r_cmd;
    logic [MAC_W-1:0]     mac;
    logic [IP_W-1:0]      ip;
    logic [4:0]           idx;
    logic [IW+4:0]        idx_ext;

    assign mac     = r_item[OFF_MAC +: MAC_W];
    assign ip      = r_item[OFF_IP +: IP_W];
    assign idx     = r_item[OFF_IDX +: 5];
    assign idx_ext = {{IW{1'b0}}, idx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_s_tdata;
            r_cmd  <= t_cmd'(i_s_tuser);
        end
    end

    // storage
    logic [MAC_W-1:0] r_if_mac [NUM_IFACES];
    logic [NUM_IFACES-1:0] r_if_flag;
    logic [IP_W-1:0]  r_tb_ip  [TABLE_ENTRIES];
    logic [MAC_W-1:0] r_tb_mac [TABLE_ENTRIES];
    logic [UW-1:0]    r_used;

    logic [CW-1:0]    r_scan_idx;
    logic             r_scan_on, r_scan_tbl, r_done, r_hit, r_cmp_vld;
    logic [CW-1:0]    r_cmp_idx;
    logic [AW-1:0]    r_hit_slot;
    logic [MAC_W-1:0] r_hit_mac;
    logic [MAC_W-1:0] r_if_mac_q, r_tb_mac_q;
    logic [IP_W-1:0]  r_tb_ip_q;
    logic             r_flag_q;
    logic [CW-1:0]    limit;
    logic             issue, cmp_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_iface && (32'(idx) < NUM_IFACES))
            r_if_mac[idx_ext[IW-1:0]] <= mac;
        r_if_mac_q <= r_if_mac[r_scan_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_if_flag <= '0;
        end else if (i_cmd.wr_iface && (32'(idx) < NUM_IFACES)) begin
            r_if_flag[idx_ext[IW-1:0]] <= r_item[OFF_RTR];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_insert)
            r_tb_ip[r_used[AW-1:0]] <= ip;
        r_tb_ip_q <= r_tb_ip[r_scan_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_insert)
            r_tb_mac[r_used[AW-1:0]] <= mac;
        else if (i_cmd.tbl_update)
            r_tb_mac[r_hit_slot] <= mac;
        r_tb_mac_q <= r_tb_mac[r_scan_idx[AW-1:0]];
    end

    // scan unit: one entry per cycle, read data registered and arriving in the cycle after the address
    assign limit   = r_scan_tbl ? CW'(r_used) : CW'(NUM_IFACES);
    assign issue   = r_scan_on && (r_scan_idx < limit);
    assign cmp_hit = r_scan_on && r_cmp_vld &&
                     (r_scan_tbl ? (r_tb_ip_q == ip)
                                 : (r_flag_q && (r_if_mac_q == mac)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_on <= 1'b0;
            r_done    <= 1'b0;
            r_hit     <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.start_if || i_cmd.start_tb) begin
            r_scan_on  <= 1'b1;
            r_scan_tbl <= i_cmd.start_tb;
            r_scan_idx <= '0;
            r_done     <= 1'b0;
            r_hit      <= 1'b0;
            r_cmp_vld  <= 1'b0;
        end else if (r_scan_on) begin
            r_flag_q  <= r_if_flag[r_scan_idx[IW-1:0]];
            r_cmp_idx <= r_scan_idx;
            r_cmp_vld <= issue;
            if (issue)
                r_scan_idx <= r_scan_idx + 1'b1;
            if (cmp_hit) begin
                r_scan_on  <= 1'b0;
                r_done     <= 1'b1;
                r_hit      <= 1'b1;
                r_hit_slot <= r_cmp_idx[AW-1:0];
                r_hit_mac  <= r_tb_mac_q;
            end else if (!issue && !r_cmp_vld) begin
                r_scan_on <= 1'b0;
                r_done    <= 1'b1;
            end
        end
    end

    // counters and fill level
    logic [CNT_W-1:0] r_req, r_rep, r_lrn, r_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_req  <= '0;
            r_rep  <= '0;
            r_lrn  <= '0;
            r_upd  <= '0;
        end else begin
            if (i_cmd.bump_req)   r_req <= r_req + 1'b1;
            if (i_cmd.bump_rep)   r_rep <= r_rep + 1'b1;
            if (i_cmd.tbl_update) r_upd <= r_upd + 1'b1;
            if (i_cmd.tbl_insert) begin
                r_lrn  <= r_lrn + 1'b1;
                r_used <= r_used + 1'b1;
            end
        end
    end

    // output register
    logic found;
    assign found = i_cmd.out_lookup && r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_m_tuser <= i_cmd.outcome;
            o_m_tdata <= {7'd0, r_upd, r_lrn, r_rep, r_req,
                          (found ? r_hit_mac : {MAC_W{1'b0}}), found};
        end
    end

    // status
    always_comb begin
        o_sts.cmd      = r_cmd;
        o_sts.frame_ok = (r_item[OFF_ETH +: 16] == ETH_ARP) && r_item[OFF_WHOLE] &&
                         (r_item[OFF_HWT +: 16] == HW_ETHER) &&
                         (r_item[OFF_PRT +: 16] == PROTO_IP4) &&
                         (r_item[OFF_HWL +: 8] == HW_LEN) &&
                         (r_item[OFF_PRL +: 8] == PROTO_LEN);
        o_sts.op_req    = r_item[OFF_OPC +: 16] == OP_REQ;
        o_sts.op_rep    = r_item[OFF_OPC +: 16] == OP_REP;
        o_sts.scan_done = r_done;
        o_sts.scan_hit  = r_hit;
        o_sts.mac_same  = r_hit_mac == mac;
        o_sts.tbl_full  = 32'(r_used) >= TABLE_ENTRIES;
        o_sts.out_busy  = o_m_tvalid && !i_m_tready;
    end

endmodule
